### sv/atlr_pkg.sv
// Shared constants and types of the antialiased thick line rasteriser.
package atlr_pkg;

  localparam int IN_COORD_W = 10;
  localparam int OUT_W      = 12;
  localparam int LEVEL_W    = 8;
  localparam int FRAC_BITS  = 8;
  localparam int SLOPE_W    = 10;
  localparam int QUOT_W     = 9;
  localparam int THICK_W    = 4;

  localparam int COORD_BITS_DEF    = 10;
  localparam int MAX_THICKNESS_DEF = 8;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [APB_ADDR_W-1:0] ADDR_THICKNESS = 3'd0;
  localparam logic [THICK_W-1:0]    THICK_RESET    = 4'd1;
  localparam logic [LEVEL_W-1:0]    FULL_COVER     = 8'hFF;

  localparam logic OPC_START = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_DIV  = 5'b00100,
    S_COL  = 5'b01000,
    S_SQR  = 5'b10000
  } state_t;

endpackage

### sv/atlr_if.sv
// Valid/ready channels for command items and emitted pixels.
interface atlr_cmd_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [atlr_pkg::IN_COORD_W-1:0]   from_x;
  logic [atlr_pkg::IN_COORD_W-1:0]   from_y;
  logic [atlr_pkg::IN_COORD_W-1:0]   to_x;
  logic [atlr_pkg::IN_COORD_W-1:0]   to_y;
  logic [atlr_pkg::LEVEL_W-1:0]      brightness;

  modport source (output valid, opcode, from_x, from_y, to_x, to_y, brightness,
                  input ready);
  modport sink (input valid, opcode, from_x, from_y, to_x, to_y, brightness,
                output ready);
endinterface

interface atlr_pix_if;
  logic                              valid;
  logic                              ready;
  logic signed [atlr_pkg::OUT_W-1:0] pixel_x;
  logic signed [atlr_pkg::OUT_W-1:0] pixel_y;
  logic [atlr_pkg::LEVEL_W-1:0]      alpha;
  logic                              last_of_item;
  logic                              line_done;

  modport source (output valid, pixel_x, pixel_y, alpha, last_of_item, line_done,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, alpha, last_of_item, line_done,
                output ready);
endinterface

### sv/atlr_div.sv
// Restoring slope divider: one compare-subtract per cycle, result truncated toward zero.
module atlr_div #(
  parameter int COORD_BITS = atlr_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                neg_in,
  input  logic [COORD_BITS-1:0]               num,
  input  logic [COORD_BITS-1:0]               den,
  output logic                                done,
  output logic signed [atlr_pkg::SLOPE_W-1:0] quot
);

  localparam int QW = atlr_pkg::QUOT_W;
  localparam int CW = $clog2(QW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [COORD_BITS:0] rem;
  logic [COORD_BITS:0] cand;
  logic [COORD_BITS:0] diff;
  logic [COORD_BITS-1:0] dvs;
  logic [QW-1:0] q;
  logic          neg;
  logic          ge;

  // first step compares num itself (quotient bit 8 is set only when |dy| == dx)
  assign cand = (cnt == '0) ? rem : {rem[COORD_BITS-1:0], 1'b0};
  assign ge   = cand >= {1'b0, dvs};
  assign diff = cand - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      dvs <= den;
      neg <= neg_in;
    end else if (busy) begin
      rem <= ge ? diff : cand;
      q   <= {q[QW-2:0], ge};
    end
  end

  assign quot = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

### sv/antialiased_thick_line_rasteriser_unit.sv
// Antialiased thick line rasteriser: fixed-point DDA over major-axis columns.
//
// cmd channel (valid/ready): opcode 0 starts a line from two endpoints and a
// brightness, opcode 1 rasterises the next major-axis column of the line.
// pix channel (valid/ready): one pixel per transaction with coordinates,
// alpha and last_of_item / line_done flags.
// APB port: one register, line_thickness at address 0 (reset 1).
// Sequencing: cmd.ready is high only while the sequencer idles.
// A start with a non-zero major delta is accepted, then swaps axes and
// orders endpoints, runs the slope divider and commits. A zero-length
// line is accepted and set up, then emits its square of clamped thickness
// squared pixels (one for thickness 0), one per cycle while not stalled.
// A step emits n pixels (1 or 2 antialiased, else the clamped thickness) at
// the same rate. Pixels leave through a single output register, so a new
// transaction is accepted while the last pixel still waits there.
// When the receiver stalls, emission pauses with the pending pixel held.
// Reset clears the line state, sets thickness to 1 and returns to idle.
module antialiased_thick_line_rasteriser_unit #(
  parameter int COORD_BITS    = atlr_pkg::COORD_BITS_DEF,
  parameter int MAX_THICKNESS = atlr_pkg::MAX_THICKNESS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  atlr_cmd_if.sink                          cmd,
  atlr_pix_if.source                        pix,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [atlr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [atlr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [atlr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int PW = COORD_BITS + 2;
  localparam int RW = COORD_BITS + atlr_pkg::FRAC_BITS + 1;
  localparam int EW = (PW > atlr_pkg::OUT_W) ? PW : atlr_pkg::OUT_W;
  localparam int KW = (MAX_THICKNESS > 1) ? $clog2(MAX_THICKNESS) : 1;
  localparam int TW = atlr_pkg::THICK_W;
  localparam int LW = atlr_pkg::LEVEL_W;

  atlr_pkg::state_t state;

  // configuration
  logic [TW-1:0] line_thickness;
  logic          cfg_wr;

  // line state
  logic                      line_active;
  logic [COORD_BITS-1:0]     current_column;
  logic [COORD_BITS-1:0]     final_column;
  logic signed [RW-1:0]      row_fixed;
  logic signed [atlr_pkg::SLOPE_W-1:0] slope_fixed;
  logic                      steep;
  logic [LW-1:0]             line_level;

  // latched start fields
  logic [COORD_BITS-1:0] fx, fy, tx, ty;
  logic [LW-1:0]         lvl_in;

  logic [KW-1:0] k, k2;

  // output register
  logic                       out_valid;
  logic signed [atlr_pkg::OUT_W-1:0] out_x, out_y;
  logic [LW-1:0]              out_alpha;
  logic                       out_last, out_done;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == atlr_pkg::ADDR_THICKNESS);
  assign prdata = (paddr == atlr_pkg::ADDR_THICKNESS) ?
                  atlr_pkg::APB_DATA_W'(line_thickness) : '0;

  logic cmd_acc;
  assign cmd.ready = (state == atlr_pkg::S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;

  // thickness bounds: run covers minor offsets -lo..hi
  logic [TW-1:0] tcl;
  logic [KW-1:0] lo, hi, span;
  logic          aa;
  always_comb begin
    tcl  = (line_thickness > TW'(MAX_THICKNESS)) ? TW'(MAX_THICKNESS) : line_thickness;
    lo   = (tcl == '0) ? '0 : KW'(TW'(tcl - 1'b1) >> 1);
    hi   = KW'(tcl >> 1);
    span = (tcl == '0) ? '0 : KW'(tcl - 1'b1);
    aa   = (hi == '0);
  end

  // start setup: axis swap and endpoint ordering
  logic [COORD_BITS-1:0] adx, ady, a0, b0, a1, b1, x0, y0, x1, y1, dx, dyabs;
  logic                  st, sw, dyneg;
  always_comb begin
    adx   = (fx >= tx) ? fx - tx : tx - fx;
    ady   = (fy >= ty) ? fy - ty : ty - fy;
    st    = ady > adx;
    a0    = st ? fy : fx;
    b0    = st ? fx : fy;
    a1    = st ? ty : tx;
    b1    = st ? tx : ty;
    sw    = a0 > a1;
    x0    = sw ? a1 : a0;
    y0    = sw ? b1 : b0;
    x1    = sw ? a0 : a1;
    y1    = sw ? b0 : b1;
    dx    = x1 - x0;
    dyneg = y1 < y0;
    dyabs = dyneg ? y0 - y1 : y1 - y0;
  end

  logic div_start, div_done;
  logic signed [atlr_pkg::SLOPE_W-1:0] div_quot;
  assign div_start = (state == atlr_pkg::S_PREP) && (dx != '0);

  atlr_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .neg_in (dyneg),
    .num    (dyabs),
    .den    (dx),
    .done   (div_done),
    .quot   (div_quot)
  );

  // pixel generation
  logic [LW-1:0]           frac;
  logic signed [COORD_BITS:0] yi;
  logic [KW-1:0]           col_last_k;
  logic                    col_end, col_last, sq_last;
  logic signed [4:0]       off, offx, offy;
  logic signed [PW-1:0]    maj, mnr, sq_x, sq_y, px_x, px_y;
  logic signed [EW-1:0]    ex_x, ex_y;
  logic [LW-1:0]           mul_b, px_alpha;
  logic [2*LW-1:0]         prod;
  logic                    px_last, px_done;
  logic                    emit, load;

  always_comb begin
    frac       = row_fixed[atlr_pkg::FRAC_BITS-1:0];
    yi         = row_fixed[RW-1:atlr_pkg::FRAC_BITS];
    col_last_k = aa ? KW'(frac != '0) : span;
    col_end    = current_column >= final_column;
    col_last   = (k == col_last_k);
    sq_last    = (k == span) && (k2 == span);
    off        = signed'(5'(k)) - (aa ? 5'sd0 : signed'(5'(lo)));
    offx       = signed'(5'(k)) - signed'(5'(lo));
    offy       = signed'(5'(k2)) - signed'(5'(lo));
    maj        = signed'(PW'(current_column));
    mnr        = PW'(yi) + PW'(off);
    sq_x       = signed'(PW'(fx)) + PW'(offx);
    sq_y       = signed'(PW'(fy)) + PW'(offy);
    mul_b      = (k == '0) ? atlr_pkg::FULL_COVER - frac : frac;
    prod       = (2*LW)'(line_level) * (2*LW)'(mul_b);
    if (state == atlr_pkg::S_SQR) begin
      px_x     = sq_x;
      px_y     = sq_y;
      px_alpha = lvl_in;
      px_last  = sq_last;
      px_done  = sq_last;
    end else begin
      px_x     = steep ? mnr : maj;
      px_y     = steep ? maj : mnr;
      px_alpha = aa ? prod[2*LW-1:LW] : line_level;
      px_last  = col_last;
      px_done  = col_last && col_end;
    end
    ex_x = EW'(px_x);
    ex_y = EW'(px_y);
  end

  assign emit = (state == atlr_pkg::S_COL) || (state == atlr_pkg::S_SQR);
  assign load = emit && (!out_valid || pix.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= atlr_pkg::S_IDLE;
      line_thickness <= atlr_pkg::THICK_RESET;
      line_active    <= 1'b0;
      current_column <= '0;
      final_column   <= '0;
      row_fixed      <= '0;
      slope_fixed    <= '0;
      steep          <= 1'b0;
      line_level     <= '0;
      k              <= '0;
      k2             <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr) line_thickness <= pwdata[TW-1:0];

      if (load) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        atlr_pkg::S_IDLE: begin
          if (cmd_acc) begin
            k  <= '0;
            k2 <= '0;
            if (cmd.opcode == atlr_pkg::OPC_START) begin
              state <= atlr_pkg::S_PREP;
            end else if (line_active) begin
              state <= atlr_pkg::S_COL;
            end
          end
        end
        atlr_pkg::S_PREP: begin
          line_active <= 1'b0;
          if (dx == '0) begin
            state <= atlr_pkg::S_SQR;
          end else begin
            row_fixed      <= signed'({1'b0, y0, {atlr_pkg::FRAC_BITS{1'b0}}});
            current_column <= x0;
            final_column   <= x1;
            steep          <= st;
            line_level     <= lvl_in;
            state          <= atlr_pkg::S_DIV;
          end
        end
        atlr_pkg::S_DIV: begin
          if (div_done) begin
            slope_fixed <= div_quot;
            line_active <= 1'b1;
            state       <= atlr_pkg::S_IDLE;
          end
        end
        atlr_pkg::S_COL: begin
          if (load) begin
            if (col_last) begin
              state <= atlr_pkg::S_IDLE;
              if (col_end) begin
                line_active <= 1'b0;
              end else begin
                current_column <= current_column + 1'b1;
                row_fixed      <= row_fixed + RW'(slope_fixed);
              end
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        atlr_pkg::S_SQR: begin
          if (load) begin
            if (k == span) begin
              k <= '0;
              if (k2 == span) begin
                state <= atlr_pkg::S_IDLE;
              end else begin
                k2 <= k2 + 1'b1;
              end
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: state <= atlr_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      fx     <= COORD_BITS'(cmd.from_x);
      fy     <= COORD_BITS'(cmd.from_y);
      tx     <= COORD_BITS'(cmd.to_x);
      ty     <= COORD_BITS'(cmd.to_y);
      lvl_in <= cmd.brightness;
    end
    if (load) begin
      out_x     <= ex_x[atlr_pkg::OUT_W-1:0];
      out_y     <= ex_y[atlr_pkg::OUT_W-1:0];
      out_alpha <= px_alpha;
      out_last  <= px_last;
      out_done  <= px_done;
    end
  end

  assign pix.valid        = out_valid;
  assign pix.pixel_x      = out_x;
  assign pix.pixel_y      = out_y;
  assign pix.alpha        = out_alpha;
  assign pix.last_of_item = out_last;
  assign pix.line_done    = out_done;

  // the walk never passes the final column
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    line_active |-> current_column <= final_column)
    else $error("current column beyond final column");

  // no line is live while its slope is still being divided
  a_div_inactive: assert property (@(posedge clk) disable iff (rst)
    state == atlr_pkg::S_DIV |-> !line_active)
    else $error("line active during division");

  // the last column ends the line
  a_line_end: assert property (@(posedge clk) disable iff (rst)
    (state == atlr_pkg::S_COL && load && col_last && col_end) |=> !line_active)
    else $error("line still active after final column");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.line_done) |-> pix.last_of_item)
    else $error("line_done without last_of_item");

endmodule
